// ----- rtl/bpa_pkg.sv -----
// Package for the bitmap page allocator: sizing constants, request and
// result payload types, and the command/status structs between controller
// and datapath. No dependencies.
package bpa_pkg;

    // Region sizing
    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_BYTES = 4096;

    // Bitmap organisation: 32 pages per word
    localparam int WORD_BITS  = 32;
    localparam int WORD_SH    = 5;
    localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PAGE_W     = WORD_AW + WORD_SH;

    // Pages held in the last word; bits above them are masked out as neither free nor used
    localparam int LAST_BITS = PAGE_COUNT - WORD_BITS * (WORD_COUNT - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

    // Free-run counter saturates just above the largest request
    localparam int RUN_W   = 11;
    localparam int RUN_MAX = 1024;

    // Request codes
    localparam logic [2:0] FUNC_ALLOC = 3'd0;
    localparam logic [2:0] FUNC_FREE  = 3'd1;
    localparam logic [2:0] FUNC_MARK  = 3'd2;
    localparam logic [2:0] FUNC_TEST  = 3'd3;
    localparam logic [2:0] FUNC_FIND  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] page_index;
        logic [9:0] count;
    } bpa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic        page_free;
    } bpa_out_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_PAGE,
        PTR_RUN
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO,
        WR_BIT,
        WR_MARK
    } wr_op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_RANGE,
        RES_NOTFOUND,
        RES_OK,
        RES_TEST,
        RES_ADDR
    } res_op_t;

    typedef struct packed {
        logic    cap_req;
        ptr_op_t ptr_op;
        logic    run_clr;
        logic    run_step;
        logic    page_take_run;
        logic    page_take_find;
        wr_op_t  wr_op;
        res_op_t res_op;
        logic    out_load;
    } bpa_cmd_t;

    typedef struct packed {
        logic [2:0] in_func;
        logic       in_count_zero;
        logic       in_page_oor;
        logic       scan_hit;
        logic       find_hit;
        logic       ptr_last;
        logic       mark_last;
        logic [2:0] req_func;
    } bpa_stat_t;

endpackage

// ----- rtl/bpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old data. No deps.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bpa_ctrl.sv -----
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg for the command and status structs.
module bpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bpa_pkg::bpa_stat_t  stat,
    output bpa_pkg::bpa_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_RMW,
        S_FIND,
        S_ADDR,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.ptr_op     = bpa_pkg::PTR_HOLD;
        cmd.wr_op      = bpa_pkg::WR_NONE;
        cmd.res_op     = bpa_pkg::RES_NONE;
        state_next     = state_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_op  = bpa_pkg::WR_ZERO;
                cmd.ptr_op = bpa_pkg::PTR_INC;
                if (stat.ptr_last)
                begin
                    cmd.ptr_op = bpa_pkg::PTR_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_req = 1'b1;
                    case (stat.in_func)
                        bpa_pkg::FUNC_ALLOC:
                        begin
                            if (stat.in_count_zero)
                            begin
                                cmd.res_op = bpa_pkg::RES_NOTFOUND;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                cmd.ptr_op  = bpa_pkg::PTR_ZERO;
                                cmd.run_clr = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        bpa_pkg::FUNC_FREE, bpa_pkg::FUNC_MARK, bpa_pkg::FUNC_TEST:
                        begin
                            if (stat.in_page_oor)
                            begin
                                cmd.res_op = bpa_pkg::RES_RANGE;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                cmd.ptr_op = bpa_pkg::PTR_PAGE;
                                state_next = S_RMW;
                            end
                        end
                        bpa_pkg::FUNC_FIND:
                        begin
                            cmd.ptr_op = bpa_pkg::PTR_ZERO;
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            cmd.res_op = bpa_pkg::RES_RANGE;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.run_step = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.page_take_run = 1'b1;
                    cmd.ptr_op        = bpa_pkg::PTR_RUN;
                    state_next        = S_MARK;
                end
                else if (stat.ptr_last)
                begin
                    cmd.res_op = bpa_pkg::RES_NOTFOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.ptr_op = bpa_pkg::PTR_INC;
                end
            end
            S_MARK:
            begin
                cmd.wr_op = bpa_pkg::WR_MARK;
                if (stat.mark_last)
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    cmd.ptr_op = bpa_pkg::PTR_INC;
                end
            end
            S_RMW:
            begin
                if (stat.req_func == bpa_pkg::FUNC_TEST)
                begin
                    cmd.res_op = bpa_pkg::RES_TEST;
                end
                else
                begin
                    cmd.wr_op  = bpa_pkg::WR_BIT;
                    cmd.res_op = bpa_pkg::RES_OK;
                end
                state_next = S_RESULT;
            end
            S_FIND:
            begin
                if (stat.find_hit)
                begin
                    cmd.page_take_find = 1'b1;
                    state_next         = S_ADDR;
                end
                else if (stat.ptr_last)
                begin
                    cmd.res_op = bpa_pkg::RES_NOTFOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.ptr_op = bpa_pkg::PTR_INC;
                end
            end
            S_ADDR:
            begin
                cmd.res_op = bpa_pkg::RES_ADDR;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.wr_op == bpa_pkg::WR_NONE))
        else $error("bitmap written while idle");
`endif

endmodule

// ----- rtl/bpa_datapath.sv -----
// Datapath of the bitmap page allocator: bitmap RAM, word pointer, run
// search, mark masks, address calculation and result registers.
// Depends on bpa_pkg and bpa_ram.
module bpa_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bpa_pkg::bpa_in_t    in_data,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  bpa_pkg::bpa_cmd_t   cmd,
    output bpa_pkg::bpa_stat_t  stat,
    output bpa_pkg::bpa_out_t   out_data
);

    localparam int AW = bpa_pkg::WORD_AW;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int RW = bpa_pkg::RUN_W;
    localparam int SH = bpa_pkg::WORD_SH;

    logic [AW-1:0] ptr_reg, ptr_next;
    logic [2:0]    func_reg;
    logic [9:0]    pidx_reg;
    logic [9:0]    count_reg;
    logic [PW-1:0] page_reg, page_next;
    logic [RW-1:0] run_reg, run_next;
    logic [PW-1:0] rstart_reg, rstart_next;
    logic [31:0]   base_reg;

    logic [1:0]    res_status_reg;
    logic [31:0]   res_addr_reg;
    logic          res_free_reg;
    bpa_pkg::bpa_out_t out_reg;

    logic          ram_we;
    logic [31:0]   ram_wdata, rdata;

    logic          ptr_last;
    logic [31:0]   vmask, freew, usedw;
    logic [5:0]    tz, lz;
    logic [4:0]    lu;
    logic [31:0]   dwin [5];
    logic [31:0]   win;
    logic [5:0]    off;
    logic          inner_ok;
    logic [4:0]    inner_pos;
    logic          carry_hit;
    logic [PW-1:0] word_base, carry_start, run_found;
    logic [11:0]   run_sum;
    logic [4:0]    used_pos;
    logic [PW-1:0] end_page;
    logic [AW-1:0] first_w, last_w;
    logic [4:0]    mark_lo, mark_hi;
    logic [31:0]   mark_mask, bit_mask;
    logic [31:0]   addr_calc;

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (bpa_pkg::WORD_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_next),
        .rdata (rdata)
    );

    assign ptr_last = (ptr_reg == AW'(bpa_pkg::WORD_COUNT - 1));
    assign vmask    = ptr_last ? bpa_pkg::LAST_MASK : 32'hFFFF_FFFF;
    assign freew    = ~rdata & vmask;
    assign usedw    = rdata & vmask;
    assign word_base = {ptr_reg, {SH{1'b0}}};

    // Trailing free pages and free pages at the top of the word
    always_comb
    begin
        tz = 6'd32;
        lu = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!freew[i])
            begin
                tz = 6'(i);
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (!freew[i])
            begin
                lu = 5'(i);
            end
        end
        lz = (&freew) ? 6'd32 : (6'd31 - {1'b0, lu});
    end

    // Runs wholly inside the word: bit i set when pages i..i+count-1 are free
    always_comb
    begin
        dwin[0] = freew;
        for (int k = 1; k < 5; k++)
        begin
            dwin[k] = dwin[k-1] & (dwin[k-1] >> (1 << (k - 1)));
        end
        win = 32'hFFFF_FFFF;
        off = 6'd0;
        for (int k = 0; k < 5; k++)
        begin
            if (count_reg[k])
            begin
                win = win & (dwin[k] >> off);
                off = off + 6'(1 << k);
            end
        end
        inner_pos = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (win[i])
            begin
                inner_pos = 5'(i);
            end
        end
        used_pos = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (usedw[i])
            begin
                used_pos = 5'(i);
            end
        end
    end

    assign inner_ok    = (count_reg[9:5] == 5'd0) && (|win);
    assign carry_hit   = (12'(run_reg) + 12'(tz)) >= 12'(count_reg);
    assign carry_start = (run_reg != '0) ? rstart_reg : word_base;
    assign run_found   = carry_hit ? carry_start : {ptr_reg, inner_pos};
    assign run_sum     = 12'(run_reg) + 12'd32;

    // Run carried into the next word
    always_comb
    begin
        run_next    = run_reg;
        rstart_next = rstart_reg;
        if (cmd.run_clr)
        begin
            run_next = '0;
        end
        else if (cmd.run_step)
        begin
            if (&freew)
            begin
                run_next    = (run_sum > 12'(bpa_pkg::RUN_MAX)) ?
                              RW'(bpa_pkg::RUN_MAX) : RW'(run_sum);
                rstart_next = carry_start;
            end
            else
            begin
                run_next    = RW'(lz);
                rstart_next = {ptr_reg, 5'(6'd32 - lz)};
            end
        end
    end

    // Mark mask for the word under the pointer
    assign end_page  = page_reg + PW'(count_reg) - PW'(1);
    assign first_w   = page_reg[PW-1:SH];
    assign last_w    = end_page[PW-1:SH];
    assign mark_lo   = (ptr_reg == first_w) ? page_reg[4:0] : 5'd0;
    assign mark_hi   = (ptr_reg == last_w) ? end_page[4:0] : 5'd31;
    assign mark_mask = (32'hFFFF_FFFF << mark_lo) & (32'hFFFF_FFFF >> (5'd31 - mark_hi));
    assign bit_mask  = 32'd1 << pidx_reg[4:0];

    always_comb
    begin
        case (cmd.ptr_op)
            bpa_pkg::PTR_ZERO: ptr_next = '0;
            bpa_pkg::PTR_INC:  ptr_next = ptr_reg + AW'(1);
            bpa_pkg::PTR_PAGE: ptr_next = AW'(in_data.page_index >> SH);
            bpa_pkg::PTR_RUN:  ptr_next = run_found[PW-1:SH];
            default:           ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        page_next = page_reg;
        if (cmd.page_take_run)
        begin
            page_next = run_found;
        end
        else if (cmd.page_take_find)
        begin
            page_next = {ptr_reg, used_pos};
        end
    end

    always_comb
    begin
        ram_we = (cmd.wr_op != bpa_pkg::WR_NONE);
        case (cmd.wr_op)
            bpa_pkg::WR_BIT:
                ram_wdata = (func_reg == bpa_pkg::FUNC_MARK) ? (rdata | bit_mask)
                                                             : (rdata & ~bit_mask);
            bpa_pkg::WR_MARK: ram_wdata = rdata | mark_mask;
            default:          ram_wdata = '0;
        endcase
    end

    // Wraps at 32 bits
    assign addr_calc = base_reg + (32'(page_reg) * 32'(bpa_pkg::PAGE_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            func_reg  <= in_data.func;
            pidx_reg  <= in_data.page_index;
            count_reg <= in_data.count;
        end
        page_reg   <= page_next;
        run_reg    <= run_next;
        rstart_reg <= rstart_next;
        case (cmd.res_op)
            bpa_pkg::RES_RANGE:
            begin
                res_status_reg <= bpa_pkg::ST_RANGE;
                res_addr_reg   <= '0;
                res_free_reg   <= 1'b0;
            end
            bpa_pkg::RES_NOTFOUND:
            begin
                res_status_reg <= bpa_pkg::ST_NOTFOUND;
                res_addr_reg   <= '0;
                res_free_reg   <= 1'b0;
            end
            bpa_pkg::RES_OK:
            begin
                res_status_reg <= bpa_pkg::ST_OK;
                res_addr_reg   <= '0;
                res_free_reg   <= 1'b0;
            end
            bpa_pkg::RES_TEST:
            begin
                res_status_reg <= bpa_pkg::ST_OK;
                res_addr_reg   <= '0;
                res_free_reg   <= ~rdata[pidx_reg[4:0]];
            end
            bpa_pkg::RES_ADDR:
            begin
                res_status_reg <= bpa_pkg::ST_OK;
                res_addr_reg   <= addr_calc;
                res_free_reg   <= 1'b0;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_reg.status    <= res_status_reg;
            out_reg.address   <= res_addr_reg;
            out_reg.page_free <= res_free_reg;
        end
    end

    assign out_data = out_reg;

    assign stat.in_func       = in_data.func;
    assign stat.in_count_zero = (in_data.count == 10'd0);
    assign stat.in_page_oor   = 17'(in_data.page_index) >= 17'(bpa_pkg::PAGE_COUNT);
    assign stat.scan_hit      = carry_hit | inner_ok;
    assign stat.find_hit      = |usedw;
    assign stat.ptr_last      = ptr_last;
    assign stat.mark_last     = (ptr_reg == last_w);
    assign stat.req_func      = func_reg;

`ifndef SYNTHESIS
    a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_op == bpa_pkg::WR_MARK) |-> (mark_mask != 32'd0))
        else $error("mark pass on a word outside the run");

    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.page_take_run |->
            ((17'(run_found) + 17'(count_reg)) <= 17'(bpa_pkg::PAGE_COUNT)))
        else $error("allocated run beyond the page region");

    a_find_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.page_take_find |-> (17'(page_next) < 17'(bpa_pkg::PAGE_COUNT)))
        else $error("used page found beyond the page region");
`endif

endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// Steps: free/mark_used update one bitmap word and test reads it; rejected requests go straight
// to the result; alloc scans S bitmap words (1..32), then marks M words (1..32); find_used
// scans S words; a search that finds nothing scans all 32 words.
// The bitmap RAM is read one word per cycle.
// One transaction in flight: the next is taken once the result is registered.
// Reset: a clearing pass writes zero to every bitmap word, with
// in_ready low; alloc_base resets to 0 and config writes are always taken.
//
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (and bpa_ram below it).
module bitmap_page_allocator (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  bpa_pkg::bpa_in_t   in_data,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output bpa_pkg::bpa_out_t  out_data,
    // alloc_base write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    bpa_pkg::bpa_cmd_t  cmd;
    bpa_pkg::bpa_stat_t stat;

    // Config writes must land only while idle; not enforced here. They never stall
    assign cfg_ready = 1'b1;

    // Sequencer: clearing pass, request decode, scan/mark loops, result hand-off
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Bitmap RAM, word-at-a-time first-fit search and the result register.
    // The result register frees the controller to take the next transaction
    // while the previous result still waits on out_ready.
    bpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

// ----- dv/tb_bitmap_page_allocator.sv -----
// Self-checking bench for bitmap_page_allocator: queue-fed request driver, result
// monitor and a bit-per-page predictor of the first-fit bitmap.
// Depends on bpa_pkg and the allocator RTL.
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned IDLE_PCT     = 18;
    localparam int unsigned MAX_RUN      = 1023;
    localparam int unsigned SWEEP_PAGES  = 128;
    localparam int unsigned MIX_ITEMS    = 45;

    // Reserved request codes: the block answers them with out_of_range
    localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
    localparam logic [2:0] FUNC_RSVD_HI = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    bpa_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bpa_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // Bench-side copy of the allocator state
    logic [PAGE_COUNT-1:0] used_map    = '0;
    logic [31:0]           region_base = '0;

    bpa_in_t  pending_requests[$];
    bpa_out_t predicted_results[$];

    int unsigned requests_queued = 0;
    int unsigned results_checked = 0;
    int unsigned errors          = 0;
    int unsigned cfg_writes      = 0;
    int unsigned allocs_granted  = 0;
    int unsigned func_seen[8];
    int unsigned cycle_count     = 0;
    int unsigned hold_count      = 0;

    // calm: no idling on either side; hold_arm: start one long receiver stall
    logic calm     = 1'b0;
    logic hold_arm = 1'b0;
    logic receiver_held;

    bitmap_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] page_address(int unsigned page);
        // 32-bit arithmetic, so the sum wraps as the hardware does
        return region_base + 32'(page) * 32'(PAGE_BYTES);
    endfunction

    // Applies one request to the bitmap copy and returns the result it yields
    function automatic bpa_out_t service_request(bpa_in_t req);
        bpa_out_t    res;
        int unsigned p;
        int unsigned run;
        int unsigned start;
        bit          found;
        res        = '0;
        res.status = ST_OK;
        run        = 0;
        start      = 0;
        found      = 1'b0;
        func_seen[req.func]++;
        case (req.func)
            FUNC_ALLOC:
            begin
                if (req.count > MAX_RUN)
                    res.status = ST_RANGE;
                else if (req.count == 0)
                    res.status = ST_NOTFOUND;
                else
                begin
                    // first fit: lowest run of count free pages
                    for (p = 0; p < PAGE_COUNT && !found; p++)
                    begin
                        if (used_map[p])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                start = p;
                            run++;
                            found = (run == req.count);
                        end
                    end
                    if (!found)
                        res.status = ST_NOTFOUND;
                    else
                    begin
                        for (p = start; p < start + req.count; p++)
                            used_map[p] = 1'b1;
                        res.address = page_address(start);
                        allocs_granted++;
                    end
                end
            end
            FUNC_FREE, FUNC_MARK:
            begin
                if (req.page_index >= PAGE_COUNT)
                    res.status = ST_RANGE;
                else
                    used_map[req.page_index] = (req.func == FUNC_MARK);
            end
            FUNC_TEST:
            begin
                if (req.page_index >= PAGE_COUNT)
                    res.status = ST_RANGE;
                else
                    res.page_free = ~used_map[req.page_index];
            end
            FUNC_FIND:
            begin
                res.status = ST_NOTFOUND;
                for (p = 0; p < PAGE_COUNT && !found; p++)
                begin
                    if (used_map[p])
                    begin
                        found       = 1'b1;
                        res.status  = ST_OK;
                        res.address = page_address(p);
                    end
                end
            end
            default:
                res.status = ST_RANGE;
        endcase
        return res;
    endfunction

    function automatic void queue_request(logic [2:0] f, logic [9:0] pg, logic [9:0] cnt);
        bpa_in_t req;
        req.func       = f;
        req.page_index = pg;
        req.count      = cnt;
        pending_requests.push_back(req);
        requests_queued++;
    endfunction

    // Random traffic: mostly small allocations against runs of frees that punch
    // holes into the map, with single-page ops, lookups and reserved codes
    task automatic queue_random_mix(input int unsigned n);
        int unsigned queued;
        int unsigned pick;
        int unsigned size_pick;
        int unsigned span;
        int unsigned first;
        int unsigned k;
        logic [9:0]  run_len;
        queued = 0;
        while (queued < n)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                span  = $urandom_range(48, 4);
                first = $urandom_range(PAGE_COUNT - 1);
                for (k = 0; k < span && first + k < PAGE_COUNT; k++)
                begin
                    queue_request(FUNC_FREE, 10'(first + k), 10'($urandom));
                    queued++;
                end
            end
            else if (pick < 40)
            begin
                size_pick = $urandom_range(99);
                if (size_pick < 2)
                    run_len = '0;
                else if (size_pick < 75)
                    run_len = 10'($urandom_range(8, 1));
                else if (size_pick < 96)
                    run_len = 10'($urandom_range(64, 9));
                else
                    run_len = 10'($urandom_range(MAX_RUN, 65));
                queue_request(FUNC_ALLOC, 10'($urandom), run_len);
                queued++;
            end
            else
            begin
                if (pick < 55)
                    queue_request(FUNC_FREE, 10'($urandom), 10'($urandom));
                else if (pick < 65)
                    queue_request(FUNC_MARK, 10'($urandom), 10'($urandom));
                else if (pick < 80)
                    queue_request(FUNC_TEST, 10'($urandom), 10'($urandom));
                else if (pick < 96)
                    queue_request(FUNC_FIND, 10'($urandom), 10'($urandom));
                else
                    queue_request(3'($urandom_range(FUNC_RSVD_HI, FUNC_RSVD_LO)),
                                  10'($urandom), 10'($urandom));
                queued++;
            end
        end
    endtask

    // Only called with no request in flight; writes are always taken but we still
    // wait for the handshake
    task automatic write_region_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        region_base  = value;
        cfg_writes++;
    endtask

    // Done once every queued request has had its result checked
    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (results_checked != requests_queued);
    endtask

    // Request driver: predicts on acceptance, then offers the next transaction
    always @(posedge clk)
    begin : request_driver
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predicted_results.push_back(service_request(in_data));
            // valid holds until taken; gaps only open between transactions
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver stall, counted here once armed
    always @(posedge clk)
    begin : stall_counter
        if (hold_arm && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    assign receiver_held = hold_arm && (hold_count < HOLD_CYCLES);

    // Result monitor: each accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        bpa_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: status %0d address %h page_free %0d",
                           out_data.status, out_data.address, out_data.page_free);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               out_data.status);
                        errors++;
                    end
                    if (out_data.address !== want.address)
                    begin
                        $error("address: expected %h, got %h", want.address,
                               out_data.address);
                        errors++;
                    end
                    if (out_data.page_free !== want.page_free)
                    begin
                        $error("page_free: expected %0d, got %0d", want.page_free,
                               out_data.page_free);
                        errors++;
                    end
                end
            end
            out_ready <= !receiver_held && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned first;
        int unsigned k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at base 0: empty map, zero count, a fill of the whole
        // map, allocation failure on a full map, holes and reserved codes
        write_region_base(32'h0000_0000);
        queue_request(FUNC_FIND,  10'h3FF, 10'h3FF);   // nothing used yet
        queue_request(FUNC_TEST,  10'd0,   10'h3FF);
        queue_request(FUNC_TEST,  10'h3FF, 10'd0);
        queue_request(FUNC_ALLOC, 10'h3FF, 10'd0);     // zero count
        queue_request(FUNC_ALLOC, 10'd0,   10'd1);     // page 0
        queue_request(FUNC_ALLOC, 10'd0,   10'h3FF);   // largest run, fills map
        queue_request(FUNC_ALLOC, 10'd0,   10'd1);     // map full
        queue_request(FUNC_FIND,  10'd0,   10'd0);
        queue_request(FUNC_FREE,  10'd0,   10'h3FF);
        queue_request(FUNC_FIND,  10'd0,   10'd0);     // lowest used moves up
        queue_request(FUNC_ALLOC, 10'h2AA, 10'd1);
        queue_request(FUNC_FREE,  10'h3FF, 10'd0);
        queue_request(FUNC_TEST,  10'h3FF, 10'd0);
        queue_request(FUNC_ALLOC, 10'd0,   10'd2);     // single hole only
        queue_request(FUNC_ALLOC, 10'd0,   10'd1);     // takes the last page
        queue_request(FUNC_FREE,  10'd512, 10'd0);
        queue_request(FUNC_FREE,  10'd513, 10'd0);
        queue_request(FUNC_FREE,  10'd514, 10'd0);
        queue_request(FUNC_ALLOC, 10'd0,   10'd3);     // exact fit in the hole
        queue_request(FUNC_FREE,  10'd700, 10'd0);
        queue_request(FUNC_TEST,  10'd700, 10'd0);
        queue_request(FUNC_MARK,  10'd700, 10'h155);
        queue_request(FUNC_TEST,  10'd700, 10'd0);
        queue_request(FUNC_RSVD_LO, 10'h3FF, 10'h3FF);
        queue_request(FUNC_RSVD_HI, 10'd0,   10'd0);
        wait_for_drain();

        // Top base: every address past page 0 wraps. Open a window first.
        write_region_base(32'hFFFF_FFFF);
        first = $urandom_range(PAGE_COUNT - SWEEP_PAGES);
        for (k = 0; k < SWEEP_PAGES; k++)
            queue_request(FUNC_FREE, 10'(first + k), 10'($urandom));
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();

        // Receiver stalls for a long stretch while requests keep coming
        write_region_base($urandom);
        hold_arm <= 1'b1;
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();
        hold_arm <= 1'b0;

        // Back-to-back traffic with no idling on either side
        write_region_base(32'hFFFF_F000);
        calm <= 1'b1;
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();
        calm <= 1'b0;

        write_region_base($urandom);
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d base settings: alloc %0d (%0d granted)",
                 results_checked, cfg_writes, func_seen[FUNC_ALLOC], allocs_granted);
        $display("free %0d, mark %0d, test %0d, find %0d, reserved codes %0d",
                 func_seen[FUNC_FREE], func_seen[FUNC_MARK], func_seen[FUNC_TEST],
                 func_seen[FUNC_FIND],
                 func_seen[FUNC_RSVD_LO] + func_seen[FUNC_RSVD_LO + 3'd1] +
                 func_seen[FUNC_RSVD_HI]);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
